[hdl/ckl_pkg.sv]
// ============================================================================
// Color-keyed layer compositor package
// Shared sizes, request codes, sequencer states and control structs.
// ============================================================================
package ckl_pkg;

    // Table and pixel memory sizes. PIXEL_WORDS is a power of two, so the
    // pixel address wraps by dropping the high bits.
    localparam int MAX_LAYERS  = 16;
    localparam int PIXEL_WORDS = 32768;

    localparam int SLOT_W   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CNT_W    = $clog2(MAX_LAYERS + 1);
    localparam int CMP_W    = (CNT_W > 4) ? CNT_W : 4;
    localparam int PIXEL_AW = $clog2(PIXEL_WORDS);

    // Request codes.
    typedef enum logic [1:0] {
        REQ_DEFINE    = 2'd0,
        REQ_MARK      = 2'd1,
        REQ_WRITE     = 2'd2,
        REQ_COMPOSITE = 2'd3
    } t_req_type;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_ADDR,
        ST_CMP,
        ST_FIN
    } t_state;

    // One layer table entry, without the drawn flag.
    typedef struct packed {
        logic signed [9:0] left;
        logic signed [9:0] top;
        logic [7:0]        width;
        logic [7:0]        height;
        logic [14:0]       base;
        logic [15:0]       key;
    } t_layer;

    // Layer table updates from the sequencer.
    typedef struct packed {
        logic              def_en;
        logic              mark_en;
        logic [SLOT_W-1:0] mark_slot;
    } t_tbl_ctrl;

    // Address unit steps from the sequencer.
    typedef struct packed {
        logic calc_en;
        logic mul_en;
        logic skip;
    } t_au_ctrl;

endpackage

[hdl/ckl_if.sv]
// ============================================================================
// Compositor channel interfaces
// Request and response channels with valid/ready handshakes.
// ============================================================================

// Request channel: one transaction per request item.
interface ckl_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [3:0]        slot;
    logic signed [9:0] coord_x;
    logic signed [9:0] coord_y;
    logic [7:0]        width;
    logic [7:0]        height;
    logic [14:0]       address;
    logic [15:0]       pixel_value;
    logic              source_opaque;
    logic              exclude_valid;

    modport source (
        output valid, req_type, slot, coord_x, coord_y, width, height,
               address, pixel_value, source_opaque, exclude_valid,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot, coord_x, coord_y, width, height,
               address, pixel_value, source_opaque, exclude_valid,
        output ready
    );
endinterface

// Response channel: one transaction per request item.
interface ckl_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] color;
    logic [3:0]  slot_index;
    logic        accepted;

    modport source (
        output valid, color, slot_index, accepted,
        input  ready
    );
    modport sink (
        input  valid, color, slot_index, accepted,
        output ready
    );
endinterface

[hdl/color_keyed_layer_compositor.sv]
// ============================================================================
// Color-keyed layer compositor
// Layer table, pixel memory and a sequenced walk that composites one pixel.
// ============================================================================
//
//  Channel   Dir  Handshake           Carries
//  i_req     in   valid/ready         request type, slot, coordinates, size,
//                                     address, pixel value, opaque, exclude
//  o_rsp     out  valid/ready         color, slot index, accepted
//  i_cfg_*   in   write enable only   background color
//
// Define, mark and write requests go from idle straight to the finish state,
// and so does a composite with an opaque source or an empty layer table. Any
// other composite walks each slot below the layer count; a skipped layer or
// one that misses the pixel gets only the offset test, a covering one the
// offset test, row multiply, pixel memory read and key compare, all through
// the one shared address unit. Reset is synchronous and active low; it clears
// the layer count and drawn flags, the background color and the sequencer. The
// block takes one request at a time; a stalled response is held while the next
// request is worked on, which then waits in ST_FIN until the response leaves.
module color_keyed_layer_compositor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ckl_req_if.sink    i_req,
    ckl_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    ckl_pkg::t_tbl_ctrl               w_tbl_ctrl;
    ckl_pkg::t_layer                  w_def;
    ckl_pkg::t_layer                  w_entry;
    ckl_pkg::t_au_ctrl                w_au_ctrl;
    logic                             w_drawn;
    logic [ckl_pkg::CNT_W-1:0]        w_count;
    logic [ckl_pkg::SLOT_W-1:0]       w_rd_idx;
    logic signed [9:0]                w_px;
    logic signed [9:0]                w_py;
    logic                             w_hit;
    logic [15:0]                      w_key;
    logic [ckl_pkg::PIXEL_AW-1:0]     w_raddr;
    logic                             w_ram_we;
    logic [ckl_pkg::PIXEL_AW-1:0]     w_ram_waddr;
    logic [15:0]                      w_ram_wdata;
    logic                             w_ram_re;
    logic [15:0]                      w_ram_rdata;

    // Request decode, layer walk and response register.
    ckl_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_count     (w_count),
        .i_drawn     (w_drawn),
        .o_rd_idx    (w_rd_idx),
        .o_tbl_ctrl  (w_tbl_ctrl),
        .o_def       (w_def),
        .o_au_ctrl   (w_au_ctrl),
        .o_px        (w_px),
        .o_py        (w_py),
        .i_hit       (w_hit),
        .i_key       (w_key),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .i_ram_rdata (w_ram_rdata)
    );

    // Layer table.
    ckl_layer_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_tbl_ctrl),
        .i_def    (w_def),
        .i_rd_idx (w_rd_idx),
        .o_entry  (w_entry),
        .o_drawn  (w_drawn),
        .o_count  (w_count)
    );

    // Shared coverage and address unit.
    ckl_addr_unit u_addr (
        .i_clk   (i_clk),
        .i_ctrl  (w_au_ctrl),
        .i_px    (w_px),
        .i_py    (w_py),
        .i_entry (w_entry),
        .o_hit   (w_hit),
        .o_addr  (w_raddr),
        .o_key   (w_key)
    );

    // Pixel memory.
    ckl_ram #(
        .WIDTH (16),
        .DEPTH (ckl_pkg::PIXEL_WORDS)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

[hdl/ckl_ram.sv]
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module ckl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ckl_layer_table.sv]
// ============================================================================
// Layer table
// Holds layer geometry, base and key per slot, the drawn flags and the count.
// ============================================================================
module ckl_layer_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ckl_pkg::t_tbl_ctrl            i_ctrl,
    input  ckl_pkg::t_layer               i_def,
    input  logic [ckl_pkg::SLOT_W-1:0]    i_rd_idx,
    output ckl_pkg::t_layer               o_entry,
    output logic                          o_drawn,
    output logic [ckl_pkg::CNT_W-1:0]     o_count
);

    ckl_pkg::t_layer               r_tab   [ckl_pkg::MAX_LAYERS];
    logic [ckl_pkg::MAX_LAYERS-1:0] r_drawn;
    logic [ckl_pkg::CNT_W-1:0]      r_count;

    // Entry payload; a define appends at the current count.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.def_en) begin
            r_tab[r_count[ckl_pkg::SLOT_W-1:0]] <= i_def;
        end
    end

    // Drawn flags and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawn <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.def_en) begin
                r_drawn[r_count[ckl_pkg::SLOT_W-1:0]] <= 1'b0;
                r_count <= r_count + ckl_pkg::CNT_W'(1);
            end
            if (i_ctrl.mark_en) begin
                r_drawn[i_ctrl.mark_slot] <= 1'b1;
            end
        end
    end

    // Read at the slot the sequencer walks.
    assign o_entry = r_tab[i_rd_idx];
    assign o_drawn = r_drawn[i_rd_idx];
    assign o_count = r_count;

endmodule

[hdl/ckl_addr_unit.sv]
// ============================================================================
// Layer address unit
// Shared coverage test and pixel address computation, reused for each layer.
// ============================================================================
module ckl_addr_unit (
    input  logic                          i_clk,
    input  ckl_pkg::t_au_ctrl             i_ctrl,
    input  logic signed [9:0]             i_px,
    input  logic signed [9:0]             i_py,
    input  ckl_pkg::t_layer               i_entry,
    output logic                          o_hit,
    output logic [ckl_pkg::PIXEL_AW-1:0]  o_addr,
    output logic [15:0]                   o_key
);

    logic signed [10:0] w_dx;
    logic signed [10:0] w_dy;
    logic [16:0]        w_sum;

    logic [7:0]  r_dx;
    logic [7:0]  r_dy;
    logic [7:0]  r_w;
    logic [14:0] r_base;
    logic [15:0] r_key;
    logic [15:0] r_prod;

    // Offset of the pixel inside the layer and the coverage test.
    assign w_dx  = 11'(i_px) - 11'(i_entry.left);
    assign w_dy  = 11'(i_py) - 11'(i_entry.top);
    assign o_hit = !i_ctrl.skip && !w_dx[10] && !w_dy[10]
                   && ($unsigned(w_dx) < 11'(i_entry.width))
                   && ($unsigned(w_dy) < 11'(i_entry.height));

    // Capture the offsets; inside a covering layer they fit in eight bits.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc_en) begin
            r_dx   <= w_dx[7:0];
            r_dy   <= w_dy[7:0];
            r_w    <= i_entry.width;
            r_base <= i_entry.base;
            r_key  <= i_entry.key;
        end
    end

    // Row offset product.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= r_dy * r_w;
        end
    end

    // Word address, wrapped to the pixel memory size.
    assign w_sum  = 17'(r_base) + 17'(r_dx) + 17'(r_prod);
    assign o_addr = ckl_pkg::PIXEL_AW'(w_sum);
    assign o_key  = r_key;

endmodule

[hdl/ckl_seq.sv]
// ============================================================================
// Compositor sequencer
// Decodes requests, walks the layer table for composites and holds results.
// ============================================================================
module ckl_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ckl_req_if.sink                       i_req,
    ckl_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [15:0]                   i_cfg_wdata,
    input  logic [ckl_pkg::CNT_W-1:0]     i_count,
    input  logic                          i_drawn,
    output logic [ckl_pkg::SLOT_W-1:0]    o_rd_idx,
    output ckl_pkg::t_tbl_ctrl            o_tbl_ctrl,
    output ckl_pkg::t_layer               o_def,
    output ckl_pkg::t_au_ctrl             o_au_ctrl,
    output logic signed [9:0]             o_px,
    output logic signed [9:0]             o_py,
    input  logic                          i_hit,
    input  logic [15:0]                   i_key,
    output logic                          o_ram_we,
    output logic [ckl_pkg::PIXEL_AW-1:0]  o_ram_waddr,
    output logic [15:0]                   o_ram_wdata,
    output logic                          o_ram_re,
    input  logic [15:0]                   i_ram_rdata
);

    ckl_pkg::t_state r_state, n_state;

    logic [ckl_pkg::SLOT_W-1:0] r_k, n_k;
    logic signed [9:0]          r_px, n_px;
    logic signed [9:0]          r_py, n_py;
    logic                       r_excl, n_excl;
    logic [3:0]                 r_ex_slot, n_ex_slot;
    logic [15:0]                r_color, n_color;
    logic [3:0]                 r_slot_idx, n_slot_idx;
    logic                       r_acc, n_acc;
    logic [15:0]                r_bg;

    logic        r_out_valid;
    logic [15:0] r_out_color;
    logic [3:0]  r_out_slot;
    logic        r_out_acc;

    logic w_last;
    logic w_out_free;
    logic w_take;

    assign w_last     = (ckl_pkg::CNT_W'(r_k) + ckl_pkg::CNT_W'(1)) == i_count;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_take     = (r_state == ckl_pkg::ST_IDLE) && i_req.valid;

    assign i_req.ready = (r_state == ckl_pkg::ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ckl_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    if ((ckl_pkg::t_req_type'(i_req.req_type) == ckl_pkg::REQ_COMPOSITE)
                        && !i_req.source_opaque && (i_count != '0)) begin
                        n_state = ckl_pkg::ST_CALC;
                    end else begin
                        n_state = ckl_pkg::ST_FIN;
                    end
                end
            end
            ckl_pkg::ST_CALC: begin
                if (i_hit) begin
                    n_state = ckl_pkg::ST_MUL;
                end else if (w_last) begin
                    n_state = ckl_pkg::ST_FIN;
                end
            end
            ckl_pkg::ST_MUL:  n_state = ckl_pkg::ST_ADDR;
            ckl_pkg::ST_ADDR: n_state = ckl_pkg::ST_CMP;
            ckl_pkg::ST_CMP: begin
                n_state = w_last ? ckl_pkg::ST_FIN : ckl_pkg::ST_CALC;
            end
            ckl_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = ckl_pkg::ST_IDLE;
                end
            end
            default: n_state = ckl_pkg::ST_IDLE;
        endcase
    end

    // Step controls and working register updates.
    always_comb begin
        n_k        = r_k;
        n_px       = r_px;
        n_py       = r_py;
        n_excl     = r_excl;
        n_ex_slot  = r_ex_slot;
        n_color    = r_color;
        n_slot_idx = r_slot_idx;
        n_acc      = r_acc;
        o_tbl_ctrl = '0;
        o_tbl_ctrl.mark_slot = ckl_pkg::SLOT_W'(i_req.slot);
        o_au_ctrl  = '0;
        o_au_ctrl.skip = !i_drawn
                         || (r_excl && (ckl_pkg::CMP_W'(r_k) == ckl_pkg::CMP_W'(r_ex_slot)));
        o_ram_we   = 1'b0;
        o_ram_re   = 1'b0;
        unique case (r_state)
            ckl_pkg::ST_IDLE: begin
                if (w_take) begin
                    n_px       = i_req.coord_x;
                    n_py       = i_req.coord_y;
                    n_excl     = i_req.exclude_valid;
                    n_ex_slot  = i_req.slot;
                    n_k        = '0;
                    n_color    = '0;
                    n_slot_idx = '0;
                    n_acc      = 1'b0;
                    unique case (ckl_pkg::t_req_type'(i_req.req_type))
                        ckl_pkg::REQ_DEFINE: begin
                            if (int'(i_count) < ckl_pkg::MAX_LAYERS) begin
                                o_tbl_ctrl.def_en = 1'b1;
                                n_slot_idx = 4'(i_count);
                                n_acc      = 1'b1;
                            end
                        end
                        ckl_pkg::REQ_MARK: begin
                            if (ckl_pkg::CMP_W'(i_req.slot) < ckl_pkg::CMP_W'(i_count)) begin
                                o_tbl_ctrl.mark_en = 1'b1;
                                n_acc = 1'b1;
                            end
                        end
                        ckl_pkg::REQ_WRITE: begin
                            if (int'(i_req.address) < ckl_pkg::PIXEL_WORDS) begin
                                o_ram_we = 1'b1;
                                n_acc    = 1'b1;
                            end
                        end
                        ckl_pkg::REQ_COMPOSITE: begin
                            n_acc   = 1'b1;
                            n_color = i_req.source_opaque ? i_req.pixel_value : r_bg;
                        end
                        default: n_acc = 1'b0;
                    endcase
                end
            end
            ckl_pkg::ST_CALC: begin
                o_au_ctrl.calc_en = 1'b1;
                if (!i_hit && !w_last) begin
                    n_k = r_k + ckl_pkg::SLOT_W'(1);
                end
            end
            ckl_pkg::ST_MUL: begin
                o_au_ctrl.mul_en = 1'b1;
            end
            ckl_pkg::ST_ADDR: begin
                o_ram_re = 1'b1;
            end
            ckl_pkg::ST_CMP: begin
                if (i_ram_rdata != i_key) begin
                    n_color = i_ram_rdata;
                end
                if (!w_last) begin
                    n_k = r_k + ckl_pkg::SLOT_W'(1);
                end
            end
            ckl_pkg::ST_FIN: begin
                n_k = r_k;
            end
            default: n_k = r_k;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ckl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_bg        <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ckl_pkg::ST_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_bg <= i_cfg_wdata;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_px       <= n_px;
        r_py       <= n_py;
        r_excl     <= n_excl;
        r_ex_slot  <= n_ex_slot;
        r_color    <= n_color;
        r_slot_idx <= n_slot_idx;
        r_acc      <= n_acc;
    end

    // Response register, loaded when the previous response has left.
    always_ff @(posedge i_clk) begin
        if ((r_state == ckl_pkg::ST_FIN) && w_out_free) begin
            r_out_color <= r_color;
            r_out_slot  <= r_slot_idx;
            r_out_acc   <= r_acc;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.color      = r_out_color;
    assign o_rsp.slot_index = r_out_slot;
    assign o_rsp.accepted   = r_out_acc;

    // Layer definition straight from the request fields.
    assign o_def.left   = i_req.coord_x;
    assign o_def.top    = i_req.coord_y;
    assign o_def.width  = i_req.width;
    assign o_def.height = i_req.height;
    assign o_def.base   = i_req.address;
    assign o_def.key    = i_req.pixel_value;

    assign o_rd_idx    = r_k;
    assign o_px        = r_px;
    assign o_py        = r_py;
    assign o_ram_waddr = ckl_pkg::PIXEL_AW'(i_req.address);
    assign o_ram_wdata = i_req.pixel_value;

endmodule
